[design/i2cbm_pkg.sv]
// Package for the I2C bit-level master: request, response word types and command codes.
package i2cbm_pkg;

   localparam logic [2:0] REQ_START = 3'd0;
   localparam logic [2:0] REQ_STOP  = 3'd1;
   localparam logic [2:0] REQ_WRITE = 3'd2;
   localparam logic [2:0] REQ_READ  = 3'd3;
   localparam logic [2:0] REQ_WAIT  = 3'd4;

   localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] req_type;
      logic [7:0] wr_byte;
      logic       send_ack;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_high;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_error;
   } rsp_word_type;

endpackage

[design/i2c_bit_level_master_unit.sv]
// I2C bit-level master: one bus tick per request word, one response word per tick.
// The response word of each taken request is registered in the output register, or in the skid entry while stalled.
// Throughput: one request word per cycle while req_stall is low; the sequencer steps once per word.
// A two-entry output stage (register plus skid) lets a word in while a response is stalled.
// Reset (synchronous, active high) idles the sequencer, releases SCL and SDA,
// clears read data and sets the acknowledge limit to 250.
module i2c_bit_level_master_unit
   import i2cbm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   typedef enum logic [5:0] {
      CMD_IDLE  = 6'b000001,
      CMD_START = 6'b000010,
      CMD_STOP  = 6'b000100,
      CMD_WRITE = 6'b001000,
      CMD_READ  = 6'b010000,
      CMD_WAIT  = 6'b100000
   } cmd_state_type;

   cmd_state_type cmd_ff, cmd_in;
   logic [4:0]    step_ff, step_in;
   logic [7:0]    shift_ff, shift_in;
   logic [7:0]    poll_ff, poll_in;
   logic          scl_ff, scl_in;
   logic          sda_ff, sda_in;
   logic          ack_choice_ff, ack_choice_in;
   logic          timeout_ff, timeout_in;
   logic [7:0]    last_read_ff, last_read_in;
   logic [7:0]    limit_ff;

   rsp_word_type  result;
   rsp_word_type  out_word_ff, skid_word_ff;
   logic          out_valid_ff, skid_valid_ff;
   logic          accept;
   logic          out_free;

   function automatic logic [1:0] mod3(input logic [4:0] v);
      logic [1:0] r;
      unique case (v)
         5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27, 5'd30: r = 2'd0;
         5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31: r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      logic       busy;
      logic       done;
      logic       err;
      logic [4:0] s;
      logic [4:0] nxt;
      cmd_in        = cmd_ff;
      step_in       = step_ff;
      shift_in      = shift_ff;
      poll_in       = poll_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_choice_in = ack_choice_ff;
      timeout_in    = timeout_ff;
      last_read_in  = last_read_ff;
      busy          = 1'b0;
      done          = 1'b0;
      err           = 1'b0;
      s             = 5'd0;
      nxt           = 5'd0;

      if (cmd_ff == CMD_IDLE && req_word.cmd_valid) begin
         step_in    = 5'd0;
         timeout_in = 1'b0;
         unique case (req_word.req_type)
            REQ_START: cmd_in = CMD_START;
            REQ_STOP:  cmd_in = CMD_STOP;
            REQ_WRITE: begin
               cmd_in   = CMD_WRITE;
               shift_in = req_word.wr_byte;
            end
            REQ_READ: begin
               cmd_in        = CMD_READ;
               shift_in      = 8'd0;
               ack_choice_in = req_word.send_ack;
            end
            REQ_WAIT: begin
               cmd_in  = CMD_WAIT;
               poll_in = 8'd0;
            end
            default: begin
               step_in    = step_ff;
               timeout_in = timeout_ff;
            end
         endcase
      end

      if (cmd_in != CMD_IDLE) begin
         busy = 1'b1;
         s    = step_in;
         nxt  = s + 5'd1;
         unique case (cmd_in)
            CMD_START: begin
               if (s == 5'd0) sda_in = 1'b1;
               else if (s == 5'd1) scl_in = 1'b1;
               else if (s == 5'd2) sda_in = 1'b0;
               else begin
                  scl_in = 1'b0;
                  done   = 1'b1;
               end
            end
            CMD_STOP: begin
               if (s == 5'd0) scl_in = 1'b0;
               else if (s == 5'd1) sda_in = 1'b0;
               else if (s == 5'd2) scl_in = 1'b1;
               else begin
                  sda_in = 1'b1;
                  done   = 1'b1;
               end
            end
            CMD_WRITE: begin
               unique case (mod3(s))
                  2'd0: begin
                     scl_in = 1'b0;
                     sda_in = shift_in[7];
                  end
                  2'd1: scl_in = 1'b1;
                  default: begin
                     scl_in   = 1'b0;
                     shift_in = {shift_in[6:0], 1'b0};
                     if (s >= 5'd23) done = 1'b1;
                  end
               endcase
            end
            CMD_READ: begin
               if (s < 5'd16) begin
                  sda_in = 1'b1;
                  if (!s[0]) begin
                     scl_in = 1'b0;
                  end else begin
                     scl_in   = 1'b1;
                     shift_in = {shift_in[6:0], req_word.sda_in};
                  end
               end else if (s == 5'd16) begin
                  scl_in = 1'b0;
                  sda_in = !ack_choice_in;
               end else if (s == 5'd17) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in       = 1'b0;
                  sda_in       = 1'b1;
                  last_read_in = shift_in;
                  done         = 1'b1;
               end
            end
            CMD_WAIT: begin
               if (s == 5'd0) begin
                  sda_in = 1'b1;
               end else if (s == 5'd1) begin
                  scl_in = 1'b1;
               end else if (s == 5'd2) begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
                  if (!req_word.sda_in) begin
                     nxt = 5'd3;
                  end else if (poll_in >= limit_ff) begin
                     cmd_in     = CMD_STOP;
                     timeout_in = 1'b1;
                     nxt        = 5'd0;
                  end else begin
                     poll_in = poll_in + 8'd1;
                     nxt     = 5'd2;
                  end
               end else begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
                  done   = 1'b1;
               end
            end
            default: begin
               cmd_in = CMD_IDLE;
               nxt    = 5'd0;
            end
         endcase
         if (done) begin
            err        = timeout_in;
            timeout_in = 1'b0;
            cmd_in     = CMD_IDLE;
            nxt        = 5'd0;
         end
         step_in = nxt;
      end

      result.scl_high    = scl_in;
      result.sda_release = sda_in;
      result.busy_res    = busy;
      result.done_res    = done;
      result.read_data   = last_read_in;
      result.ack_error   = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= CMD_IDLE;
         step_ff       <= 5'd0;
         shift_ff      <= 8'd0;
         poll_ff       <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_choice_ff <= 1'b0;
         timeout_ff    <= 1'b0;
         last_read_ff  <= 8'd0;
      end else if (accept) begin
         cmd_ff        <= cmd_in;
         step_ff       <= step_in;
         shift_ff      <= shift_in;
         poll_ff       <= poll_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         ack_choice_ff <= ack_choice_in;
         timeout_ff    <= timeout_in;
         last_read_ff  <= last_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ACK_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // output register with a skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_word_ff <= skid_word_ff;
         end else if (accept) begin
            out_word_ff <= result;
         end
      end else if (accept) begin
         skid_word_ff <= result;
      end
   end

endmodule

[design/i2cbm_checker.sv]
// Port-level assertions for the I2C bit-level master, bound to i2c_bit_level_master_unit.
module i2cbm_checker
   import i2cbm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.done_res |-> rsp_word.busy_res)
      else $error("done without busy");

   a_err_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.ack_error |->
         rsp_word.done_res && rsp_word.scl_high && rsp_word.sda_release)
      else $error("ack error not on a completed stop");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("stalled request word changed");

endmodule

bind i2c_bit_level_master_unit i2cbm_checker u_i2cbm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_word    (req_word),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_word    (rsp_word)
);
